// ===== rtl/core/srld_pkg.sv =====
// Shared types and constants for the sprite RLE line decoder.
// Used by every module of the block; depends on nothing.
package srld_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LINE_WIDTH_RESET = 8'd64;

  // Register addresses are decoded on paddr[2]; register 0 sits at byte 0.
  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_LINE_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    KIND_TRANSPARENT = 2'd0,
    KIND_FILL        = 2'd1,
    KIND_LITERAL     = 2'd2
  } run_kind_t;

  typedef struct packed {
    logic       line_start;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] run_start;
    logic [6:0] run_length;
    logic [7:0] pixel_value;
    logic [1:0] run_kind;
    logic       line_done;
  } out_item_t;

endpackage

// ===== rtl/core/srld_front.sv =====
// Front end: accepts code bytes, tracks the run phase and column, and
// builds run descriptors. Depends on srld_pkg.
module srld_front import srld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  input  logic [7:0] line_width,
  output logic      push,
  output out_item_t push_item
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_FILL    = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [5:0] remaining_r, remaining_nxt;
  logic [5:0] pending_r, pending_nxt;
  logic [8:0] column_r, column_nxt;
  logic       complete_r, complete_nxt;

  phase_t     phase_eff;
  logic       emit;
  logic [6:0] emit_len;
  logic [7:0] emit_value;
  run_kind_t  emit_kind;
  logic [9:0] run_end;
  logic       run_done;
  logic       live;
  logic [7:0] b;
  logic [5:0] rem_dec;
  logic [8:0] col_base;

  assign b       = item.code_byte;
  assign rem_dec = remaining_r - 6'd1;

  // Column after a possible line restart, before the run is added.
  assign col_base = item.line_start ? 9'd0 : column_r;

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    pending_nxt   = pending_r;
    column_nxt    = column_r;
    complete_nxt  = complete_r;
    emit          = 1'b0;
    emit_len      = 7'd0;
    emit_value    = 8'd0;
    emit_kind     = KIND_TRANSPARENT;
    phase_eff     = phase_r;
    live          = 1'b0;
    run_end       = 10'd0;
    run_done      = 1'b0;

    if (accept) begin
      if (item.line_start) begin
        phase_eff     = PH_HEADER;
        remaining_nxt = 6'd0;
        pending_nxt   = 6'd0;
        column_nxt    = 9'd0;
        complete_nxt  = 1'b0;
        live          = 1'b1;
      end else begin
        live = !complete_r;
      end
    end

    if (live) begin
      case (phase_eff)
        PH_FILL: begin
          phase_nxt   = PH_HEADER;
          pending_nxt = 6'd0;
          emit        = (pending_r != 6'd0);
          emit_len    = {1'b0, pending_r};
          emit_value  = b;
          emit_kind   = KIND_FILL;
        end
        PH_LITERAL: begin
          remaining_nxt = rem_dec;
          if (rem_dec == 6'd0) begin
            phase_nxt = PH_HEADER;
          end
          emit       = 1'b1;
          emit_len   = 7'd1;
          emit_value = b;
          emit_kind  = KIND_LITERAL;
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (b[7]) begin
            emit      = (b[6:0] != 7'd0);
            emit_len  = b[6:0];
            emit_kind = KIND_TRANSPARENT;
          end else if (b[6]) begin
            pending_nxt = b[5:0];
            phase_nxt   = PH_FILL;
          end else if (b != 8'd0) begin
            remaining_nxt = b[5:0];
            phase_nxt     = PH_LITERAL;
          end
        end
      endcase

      run_end  = {1'b0, col_base} + {3'b000, emit_len};
      run_done = (run_end >= {2'b00, line_width});

      if (emit) begin
        column_nxt = run_end[8:0];
        if (run_done) begin
          complete_nxt  = 1'b1;
          phase_nxt     = PH_HEADER;
          remaining_nxt = 6'd0;
          pending_nxt   = 6'd0;
        end
      end
    end
  end

  assign push                  = emit;
  assign push_item.run_start   = col_base[7:0];
  assign push_item.run_length  = emit_len;
  assign push_item.pixel_value = emit_value;
  assign push_item.run_kind    = emit_kind;
  assign push_item.line_done   = run_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      remaining_r <= 6'd0;
      pending_r   <= 6'd0;
      column_r    <= 9'd0;
      complete_r  <= 1'b1;
    end else begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      pending_r   <= pending_nxt;
      column_r    <= column_nxt;
      complete_r  <= complete_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && complete_r && !item.line_start) |-> !push)
    else $error("byte after line end produced a run");

  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_item.line_done) |=> (complete_r && phase_r == PH_HEADER))
    else $error("line end did not close the line");

  a_nonzero_run: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_item.run_length != 7'd0))
    else $error("zero-length run emitted");
`endif

endmodule

// ===== rtl/core/srld_queue.sv =====
// Two-entry descriptor queue between the decode front end and the output
// stage. Depends on srld_pkg.
module srld_queue import srld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      not_full,
  output logic      q_valid,
  output out_item_t q_item,
  input  logic      pop
);

  out_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign not_full = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== rtl/core/srld_back.sv =====
// Output stage: pulls descriptors from the queue into the result register
// and drives the result channel. Depends on srld_pkg.
module srld_back import srld_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  out_item_t q_item,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // Refill whenever the register is empty or is being drained this cycle.
  assign pop       = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sprite_rle_line_decoder.sv =====
// Sprite RLE line decoder top level: config register, front end, queue and
// output stage. Depends on srld_pkg, srld_front, srld_queue, srld_back.
//
// Usage:
//   in_*  : one code byte per transaction (in_data.code_byte), with
//           in_data.line_start marking the first byte of a line.
//   out_* : one run descriptor per transaction: start column, length,
//           palette value (0 when transparent), kind, and line_done on the
//           run that reaches line_width.
//   cfg_* : APB-style write of line_width at byte address 0; pready is
//           always high and reads return the current value.
// Throughput is one byte per cycle while the queue is not full. The front
// end writes the queue at the edge that accepts a byte, and the output
// register loads from the queue once it is empty or being drained, which
// raises out_valid. Literal headers, fill headers, zero-length transparent
// headers and ignored bytes produce no descriptor.
// After reset line_width is 64 and the decoder ignores bytes until a
// transaction with line_start set. If the receiver stalls, the output
// register and the two-entry queue absorb descriptors; in_ready drops only
// when the queue is full, and nothing is dropped or reordered.
module sprite_rle_line_decoder import srld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [7:0] line_width_r;
  logic       cfg_write;
  logic       accept;
  logic       push;
  out_item_t  push_item;
  logic       not_full;
  logic       q_valid;
  out_item_t  q_item;
  logic       pop;

  // Configuration: single register, write in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_LINE_WIDTH) ? {24'd0, line_width_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_write && cfg_paddr[2] == REG_LINE_WIDTH) begin
      line_width_r <= cfg_pwdata[7:0];
    end
  end

  // Accept a byte whenever the queue can take a possible descriptor.
  assign in_ready = not_full;
  assign accept   = in_valid && in_ready;

  srld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_data),
    .line_width (line_width_r),
    .push       (push),
    .push_item  (push_item)
  );

  srld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .not_full  (not_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  srld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
